[rtl/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

   localparam int WordWidth = 32;

   localparam logic [WordWidth-1:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WordWidth-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic load_byte;
      logic load_len;
      logic [7:0] byte_val;
      logic add_len;
      logic start;
      logic restart;
      logic [2:0] out_sel;
   } sha_cmd_type;

   typedef struct packed {
      logic busy;
      logic [5:0] fill;
   } sha_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

[rtl/sha256_hasher.sv]
`timescale 1ns / 1ps
// channel | ports | contents
// request | req_tvalid/tready/tdata/tuser/tlast | data_byte, byte_present, last
// response | rsp_tvalid/tready/tdata/tuser/tlast | digest_word, word_index, digest_last
// One byte a cycle while the block fills; a full block holds req_tready low through
// start, 64 rounds at one per cycle in a single round unit, final add and handoff.
// The last transaction adds padding at one byte a cycle, one or two block
// compressions, then eight response words. Reset is synchronous active high.
module sha256_hasher (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic req_tuser,         // byte_present
   input  logic req_tlast,         // last
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,  // digest_word
   output logic [2:0] rsp_tuser,   // word_index
   output logic rsp_tlast          // digest_last
);
   import sha_pkg::*;

   sha_cmd_type cmd;
   sha_stat_type stat;

   sha_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_present(req_tuser), .in_last(req_tlast),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_idx(rsp_tuser),
      .cmd(cmd), .stat(stat)
   );

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .word_out(rsp_tdata)
   );

   assign rsp_tlast = (rsp_tuser == 3'd7);
endmodule

[rtl/sha_datapath.sv]
`timescale 1ns / 1ps
module sha_datapath (
   input  logic clock,
   input  logic reset,
   input  sha_pkg::sha_cmd_type cmd,
   output sha_pkg::sha_stat_type stat,
   output logic [31:0] word_out
);
   import sha_pkg::*;

   // bytes always arrive in block order, so the block is a byte shift register
   logic [511:0] blk_ff;
   logic [5:0] fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [6:0] rnd_ff, rnd_in;
   logic busy_ff, busy_in;
   logic [31:0] wcur, wnew, s0, s1, t1, t2, e, a;
   logic [7:0] len_byte, next_byte;

   assign stat.busy = busy_ff;
   assign stat.fill = fill_ff;
   assign word_out = h_ff[cmd.out_sel];

   // round 0..15 read the loaded window, later rounds extend the schedule window
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      wcur = (rnd_ff < 7'd16) ? w_ff[rnd_ff[3:0]] : wnew;
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
           ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[rnd_ff[5:0]] + wcur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
           ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      // length bytes go in big-endian at fill 56..63
      len_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
      next_byte = cmd.load_len ? len_byte : cmd.byte_val;
      fill_in = fill_ff;
      bits_in = bits_ff;
      busy_in = busy_ff;
      rnd_in = rnd_ff;
      if (cmd.load_byte) fill_in = fill_ff + 6'd1;
      if (cmd.add_len) bits_in = bits_ff + 64'd8;
      if (cmd.start) begin
         busy_in = 1'b1;
         rnd_in = '0;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd64) busy_in = 1'b0;
      end
      if (cmd.restart) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
         busy_ff <= 1'b0;
         rnd_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= IV[i];
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         busy_ff <= busy_in;
         rnd_ff <= rnd_in;
         if (cmd.load_byte) blk_ff <= {blk_ff[503:0], next_byte};
         if (cmd.start) begin
            for (int i = 0; i < 16; i++) w_ff[i] <= blk_ff[511-32*i -: 32];
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end else if (busy_ff && rnd_ff < 7'd64) begin
            if (rnd_ff >= 7'd16) begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
            end
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= e;
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= a;
            v_ff[0] <= t1 + t2;
         end else if (busy_ff) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (cmd.restart)
            for (int i = 0; i < 8; i++) h_ff[i] <= IV[i];
      end
   end

`ifndef SYNTHESIS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.load_byte) else $error("store written during rounds");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("start while busy");
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rnd_ff <= 7'd64) else $error("round overrun");
`endif
endmodule

[rtl/sha_ctrl.sv]
`timescale 1ns / 1ps
module sha_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [7:0] in_byte,
   input  logic in_present,
   input  logic in_last,
   output logic out_valid,
   input  logic out_ready,
   output logic [2:0] out_idx,
   output sha_pkg::sha_cmd_type cmd,
   input  sha_pkg::sha_stat_type stat
);
   import sha_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_HASH = 3'd1, S_PAD = 3'd2, S_PZERO = 3'd3,
      S_PLEN = 3'd4, S_HASHP = 3'd5, S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic final_ff, final_in;
   logic acc;

   // padding phase tracking: set once the 0x80 byte is in, cleared at restart
   logic pad_cont_ff, pad_cont_in;
   logic len_done_ff, len_done_in;
   function automatic logic in_last_pending();
      in_last_pending = !len_done_ff;
   endfunction

   assign in_ready = (state_ff == S_IDLE);
   assign acc = in_valid && in_ready;
   assign out_valid = (state_ff == S_OUT);
   assign out_idx = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      final_in = final_ff;
      cmd = '0;
      cmd.out_sel = idx_ff;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            cmd.load_byte = in_present;
            cmd.add_len = in_present;
            cmd.byte_val = in_byte;
            final_in = in_last;
            if (in_present && stat.fill == 6'd63) begin
               state_in = S_HASH;
            end else if (in_last) state_in = S_PAD;
         end
         S_HASH: begin
            cmd.start = 1'b1;
            state_in = S_HASHP;
         end
         S_PAD: begin
            cmd.load_byte = 1'b1;
            cmd.byte_val = PAD_BYTE;
            final_in = 1'b0;
            state_in = (stat.fill == 6'd63) ? S_HASH
                     : (stat.fill == 6'd55) ? S_PLEN : S_PZERO;
         end
         S_PZERO: begin
            cmd.load_byte = 1'b1;
            if (stat.fill == 6'd63) state_in = S_HASH;
            else if (stat.fill == 6'd55) state_in = S_PLEN;
         end
         S_PLEN: begin
            cmd.load_byte = 1'b1;
            cmd.load_len = 1'b1;
            if (stat.fill == 6'd63) begin
               final_in = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASHP: if (!stat.busy) begin
            if (final_ff && stat.fill == 6'd0 && !in_last_pending()) begin
               state_in = S_OUT;
               idx_in = '0;
            end else if (final_ff) state_in = S_PAD;
            else if (pad_cont_ff) state_in = S_PZERO;
            else state_in = S_IDLE;
         end
         S_OUT: if (out_ready) begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               cmd.restart = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pad_cont_in = pad_cont_ff;
      len_done_in = len_done_ff;
      if (state_ff == S_PAD) pad_cont_in = 1'b1;
      if (state_ff == S_PLEN && stat.fill == 6'd63) len_done_in = 1'b1;
      if (cmd.restart) begin
         pad_cont_in = 1'b0;
         len_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         final_ff <= 1'b0;
         pad_cont_ff <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         final_ff <= final_in;
         pad_cont_ff <= pad_cont_in;
         len_done_ff <= len_done_in;
      end
   end

`ifndef SYNTHESIS
   a_out_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(idx_ff)) else $error("output dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("input and output overlap");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |-> idx_ff == 3'd7) else $error("early restart");
`endif
endmodule
